// ===== hw/rtl/dfp_pkg.sv =====
// ----------------------------------------------------------------------------
// dfp_pkg
// shared types and constants of the delimited frame parser
// ----------------------------------------------------------------------------
package dfp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_TOTAL  = 3'd1,
    PH_CMDLEN = 3'd2,
    PH_CMD    = 3'd3,
    PH_FMTLEN = 3'd4,
    PH_FMT    = 3'd5,
    PH_DATA   = 3'd6,
    PH_END    = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    K_HEADER = 3'd0,
    K_CMD    = 3'd1,
    K_FMT    = 3'd2,
    K_DATA   = 3'd3,
    K_ACCEPT = 3'd4,
    K_ERROR  = 3'd5
  } kind_t;

  localparam logic [7:0] START_MARK    = 8'h3C;
  localparam logic [7:0] END_MARK      = 8'h3E;
  localparam logic [9:0] LENGTH_FIELDS = 10'd2;

endpackage

// ===== hw/rtl/delimited_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// delimited_frame_parser_top
// byte-serial parser for '<' total cmdlen cmd fmtlen fmt data '>' frames
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, in_rx_byte) takes one received word
// per cycle while in_stall is low. For every word one result word leaves on
// the output channel (out_valid, out_stall, out_byte, out_kind, out_position,
// out_last_in_section) classifying it as header, command, format or data
// byte, frame accept or frame error.
// The parser state and the classification are updated at the accepting edge
// and the result is held in an output register, so it appears in the cycle
// after the word is accepted. Throughput is one word per cycle while in_stall
// is low, with a single phase and counter update per word.
// While out_stall is high with a result pending, in_stall is raised and the
// held result stays unchanged; a new word is taken in the same cycle the
// pending result is removed.
// Reset (rst_n low, synchronous) returns the parser to idle, clears the
// lengths and counters and empties the output register.
// ----------------------------------------------------------------------------
module delimited_frame_parser_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [2:0] out_kind,
  output logic [7:0] out_position,
  output logic       out_last_in_section
);

  dfp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] total_len_r, total_len_nxt;
  logic [7:0] cmd_len_r, cmd_len_nxt;
  logic [7:0] fmt_len_r, fmt_len_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] sect_idx_r, sect_idx_nxt;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  dfp_pkg::kind_t out_kind_r, kind_nxt;
  logic [7:0]  out_pos_r, pos_nxt;
  logic        out_last_r, last_nxt;

  logic              acc;
  logic [7:0]        fmt_src;
  logic signed [9:0] data_n;
  logic              data_pos;

  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;

  // data count uses the incoming format length when it is being received
  assign fmt_src  = (phase_r == dfp_pkg::PH_FMTLEN) ? in_rx_byte : fmt_len_r;
  assign data_n   = $signed({2'b00, total_len_r} - dfp_pkg::LENGTH_FIELDS
                    - {2'b00, cmd_len_r} - {2'b00, fmt_src});
  assign data_pos = (data_n > 10'sd0);

  always_comb begin
    phase_nxt      = phase_r;
    total_len_nxt  = total_len_r;
    cmd_len_nxt    = cmd_len_r;
    fmt_len_nxt    = fmt_len_r;
    bytes_left_nxt = bytes_left_r;
    sect_idx_nxt   = sect_idx_r;
    kind_nxt       = dfp_pkg::K_HEADER;
    pos_nxt        = 8'd0;
    last_nxt       = 1'b0;
    case (phase_r)
      dfp_pkg::PH_IDLE: begin
        if (in_rx_byte == dfp_pkg::START_MARK) begin
          phase_nxt = dfp_pkg::PH_TOTAL;
        end else begin
          kind_nxt = dfp_pkg::K_ERROR;
        end
      end
      dfp_pkg::PH_TOTAL: begin
        total_len_nxt = in_rx_byte;
        phase_nxt     = dfp_pkg::PH_CMDLEN;
      end
      dfp_pkg::PH_CMDLEN: begin
        cmd_len_nxt  = in_rx_byte;
        sect_idx_nxt = 8'd0;
        if (in_rx_byte != 8'd0) begin
          phase_nxt      = dfp_pkg::PH_CMD;
          bytes_left_nxt = in_rx_byte;
        end else begin
          phase_nxt      = dfp_pkg::PH_FMTLEN;
          bytes_left_nxt = 8'd0;
        end
      end
      dfp_pkg::PH_FMTLEN: begin
        fmt_len_nxt  = in_rx_byte;
        sect_idx_nxt = 8'd0;
        if (in_rx_byte != 8'd0) begin
          phase_nxt      = dfp_pkg::PH_FMT;
          bytes_left_nxt = in_rx_byte;
        end else if (data_pos) begin
          phase_nxt      = dfp_pkg::PH_DATA;
          bytes_left_nxt = data_n[7:0];
        end else begin
          phase_nxt      = dfp_pkg::PH_END;
          bytes_left_nxt = 8'd0;
        end
      end
      dfp_pkg::PH_CMD, dfp_pkg::PH_FMT, dfp_pkg::PH_DATA: begin
        if (phase_r == dfp_pkg::PH_CMD) begin
          kind_nxt = dfp_pkg::K_CMD;
        end else if (phase_r == dfp_pkg::PH_FMT) begin
          kind_nxt = dfp_pkg::K_FMT;
        end else begin
          kind_nxt = dfp_pkg::K_DATA;
        end
        pos_nxt        = sect_idx_r;
        last_nxt       = (bytes_left_r <= 8'd1);
        sect_idx_nxt   = sect_idx_r + 8'd1;
        bytes_left_nxt = bytes_left_r - 8'd1;
        if (last_nxt) begin
          sect_idx_nxt = 8'd0;
          if (phase_r == dfp_pkg::PH_CMD) begin
            phase_nxt      = dfp_pkg::PH_FMTLEN;
            bytes_left_nxt = 8'd0;
          end else if (phase_r == dfp_pkg::PH_FMT && data_pos) begin
            phase_nxt      = dfp_pkg::PH_DATA;
            bytes_left_nxt = data_n[7:0];
          end else begin
            phase_nxt      = dfp_pkg::PH_END;
            bytes_left_nxt = 8'd0;
          end
        end
      end
      dfp_pkg::PH_END: begin
        kind_nxt  = (in_rx_byte == dfp_pkg::END_MARK) ? dfp_pkg::K_ACCEPT
                                                      : dfp_pkg::K_ERROR;
        phase_nxt = dfp_pkg::PH_IDLE;
      end
      default: begin
        phase_nxt = dfp_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= dfp_pkg::PH_IDLE;
      total_len_r  <= 8'd0;
      cmd_len_r    <= 8'd0;
      fmt_len_r    <= 8'd0;
      bytes_left_r <= 8'd0;
      sect_idx_r   <= 8'd0;
    end else if (acc) begin
      phase_r      <= phase_nxt;
      total_len_r  <= total_len_nxt;
      cmd_len_r    <= cmd_len_nxt;
      fmt_len_r    <= fmt_len_nxt;
      bytes_left_r <= bytes_left_nxt;
      sect_idx_r   <= sect_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (acc) begin
      out_byte_r <= in_rx_byte;
      out_kind_r <= kind_nxt;
      out_pos_r  <= pos_nxt;
      out_last_r <= last_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_byte            = out_byte_r;
  assign out_kind            = out_kind_r;
  assign out_position        = out_pos_r;
  assign out_last_in_section = out_last_r;

endmodule

// ===== sim/delimited_frame_parser_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_frame_parser_top_tb
// Drives framed byte streams into the parser and checks every result word.
// A scoreboard class tracks the frame phase, the lengths and the section
// counters, and predicts the class, position and last mark of each word.
// The stream mixes good frames, frames with empty or clamped sections, bad
// end delimiters and stray bytes. Both sides idle at random, and the run
// also includes a long receiver hold-off and a full drain on the sender side.
// ----------------------------------------------------------------------------
module delimited_frame_parser_top_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int WORD_TARGET    = 750;

  typedef struct {
    logic [7:0]      b;
    dfp_pkg::kind_t  kind;
    logic [7:0]      pos;
    logic            last;
  } parse_result_t;

  class frame_scoreboard;
    dfp_pkg::phase_t ph = dfp_pkg::PH_IDLE;
    logic [7:0]    total_len = '0;
    logic [7:0]    cmd_len = '0;
    logic [7:0]    fmt_len = '0;
    logic [7:0]    remaining = '0;
    logic [7:0]    idx = '0;
    parse_result_t expected_q[$];
    int            errors = 0;
    int            checked = 0;
    int            accepted_frames = 0;
    int            bad_frames = 0;

    function void open_section(dfp_pkg::phase_t next_ph, logic [7:0] count);
      ph = next_ph;
      remaining = count;
      idx = '0;
    endfunction

    function void open_data();
      int n;
      n = int'(total_len) - int'(dfp_pkg::LENGTH_FIELDS) - int'(cmd_len) - int'(fmt_len);
      if (n > 0) open_section(dfp_pkg::PH_DATA, n[7:0]);
      else open_section(dfp_pkg::PH_END, '0);
    endfunction

    function void note_word(logic [7:0] b);
      parse_result_t r;
      r.b = b;
      r.kind = dfp_pkg::K_HEADER;
      r.pos = '0;
      r.last = 1'b0;
      case (ph)
        dfp_pkg::PH_IDLE: begin
          if (b == dfp_pkg::START_MARK) ph = dfp_pkg::PH_TOTAL;
          else r.kind = dfp_pkg::K_ERROR;
        end
        dfp_pkg::PH_TOTAL: begin
          total_len = b;
          ph = dfp_pkg::PH_CMDLEN;
        end
        dfp_pkg::PH_CMDLEN: begin
          cmd_len = b;
          if (b != 0) open_section(dfp_pkg::PH_CMD, b);
          else open_section(dfp_pkg::PH_FMTLEN, '0);
        end
        dfp_pkg::PH_FMTLEN: begin
          fmt_len = b;
          if (b != 0) open_section(dfp_pkg::PH_FMT, b);
          else open_data();
        end
        dfp_pkg::PH_CMD, dfp_pkg::PH_FMT, dfp_pkg::PH_DATA: begin
          r.kind = (ph == dfp_pkg::PH_CMD) ? dfp_pkg::K_CMD :
                   (ph == dfp_pkg::PH_FMT) ? dfp_pkg::K_FMT : dfp_pkg::K_DATA;
          r.pos = idx;
          r.last = (remaining <= 1);
          idx = idx + 8'd1;
          remaining = remaining - 8'd1;
          if (r.last) begin
            if (ph == dfp_pkg::PH_CMD) open_section(dfp_pkg::PH_FMTLEN, '0);
            else if (ph == dfp_pkg::PH_FMT) open_data();
            else open_section(dfp_pkg::PH_END, '0);
          end
        end
        default: begin
          r.kind = (b == dfp_pkg::END_MARK) ? dfp_pkg::K_ACCEPT : dfp_pkg::K_ERROR;
          ph = dfp_pkg::PH_IDLE;
        end
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [7:0] b, logic [2:0] kind, logic [7:0] pos,
                               logic last);
      parse_result_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result word: byte %0h kind %0d", b, kind);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (e.kind == dfp_pkg::K_ACCEPT) accepted_frames++;
      if (e.kind == dfp_pkg::K_ERROR) bad_frames++;
      if (b !== e.b) begin
        $error("out_byte: expected %0h, actual %0h", e.b, b);
        errors++;
      end
      if (kind !== e.kind) begin
        $error("out_kind: expected %0d, actual %0d", e.kind, kind);
        errors++;
      end
      if (pos !== e.pos) begin
        $error("out_position: expected %0d, actual %0d", e.pos, pos);
        errors++;
      end
      if (last !== e.last) begin
        $error("out_last_in_section: expected %0b, actual %0b", e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic [2:0] out_kind;
  logic [7:0] out_position;
  logic       out_last_in_section;

  frame_scoreboard sb = new();
  int  words_in = 0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;
  int  quiet_cycles = 0;

  delimited_frame_parser_top uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_byte            (out_byte),
    .out_kind            (out_kind),
    .out_position        (out_position),
    .out_last_in_section (out_last_in_section)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic send_word(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_word(b);
    words_in++;
  endtask

  task automatic send_frame(input logic [7:0] total, input logic [7:0] cmd_n,
                            input logic [7:0] fmt_n, input bit bad_end);
    int         n_data;
    logic [7:0] tail;
    n_data = int'(total) - 2 - int'(cmd_n) - int'(fmt_n);
    send_word(dfp_pkg::START_MARK);
    send_word(total);
    send_word(cmd_n);
    repeat (cmd_n) send_word(8'($urandom_range(255)));
    send_word(fmt_n);
    repeat (fmt_n) send_word(8'($urandom_range(255)));
    if (n_data > 0) repeat (n_data) send_word(8'($urandom_range(255)));
    tail = dfp_pkg::END_MARK;
    if (bad_end) while (tail == dfp_pkg::END_MARK) tail = 8'($urandom_range(255));
    send_word(tail);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // receiver side
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall)
        sb.check_result(out_byte, out_kind, out_position, out_last_in_section);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 15);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("delimited_frame_parser_top_tb: FAIL");
      $finish;
    end
  end

  initial begin
    bit         done_hold;
    bit         done_drain;
    int         pick;
    int         data_n;
    logic [7:0] cmd_n;
    logic [7:0] fmt_n;
    logic [7:0] total;
    done_hold = 1'b0;
    done_drain = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_rx_byte <= 8'h00;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: stray bytes, empty sections, one of each, clamp, bad end
    send_word(8'h00);
    send_word(8'hFF);
    send_frame(8'd2, 8'd0, 8'd0, 1'b0);
    send_frame(8'd5, 8'd1, 8'd1, 1'b0);
    send_frame(8'd0, 8'd1, 8'd1, 1'b0);
    send_frame(8'd2, 8'd0, 8'd0, 1'b1);

    while (words_in < WORD_TARGET) begin
      calm = (words_in >= 300 && words_in < 420);
      if (!done_hold && words_in >= 150) begin
        done_hold = 1'b1;
        hold_req = 1'b1;
      end
      if (!done_drain && words_in >= 500) begin
        done_drain = 1'b1;
        drain_results();
      end
      pick = $urandom_range(99);
      cmd_n = 8'($urandom_range(5));
      fmt_n = 8'($urandom_range(5));
      data_n = $urandom_range(6);
      if (pick < 3 && words_in < WORD_TARGET - 300) begin
        case ($urandom_range(2))
          0: begin
            cmd_n = 8'($urandom_range(128, 255));
            total = 8'($urandom_range(255));
          end
          1: begin
            fmt_n = 8'($urandom_range(128, 255));
            total = 8'($urandom_range(255));
          end
          default: total = 8'($urandom_range(128, 255));
        endcase
        send_frame(total, cmd_n, fmt_n, $urandom_range(3) == 0);
      end else if (pick < 13) begin
        repeat ($urandom_range(1, 4)) begin
          total = 8'($urandom_range(255));
          if (total == dfp_pkg::START_MARK) total = dfp_pkg::END_MARK;
          send_word(total);
        end
      end else if (pick < 23) begin
        if ($urandom_range(1) == 1) begin
          send_frame(8'(cmd_n + fmt_n + data_n + 2), cmd_n, fmt_n, 1'b1);
        end else begin
          total = 8'($urandom_range(int'(cmd_n) + int'(fmt_n) + 1));
          send_frame(total, cmd_n, fmt_n, $urandom_range(1) == 1);
        end
      end else begin
        send_frame(8'(cmd_n + fmt_n + data_n + 2), cmd_n, fmt_n, 1'b0);
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (4) @(posedge clk);
    $display("run covered %0d input words and %0d checked results", words_in, sb.checked);
    $display("frames accepted: %0d, error words: %0d", sb.accepted_frames, sb.bad_frames);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("delimited_frame_parser_top_tb: PASS");
    end else begin
      $display("delimited_frame_parser_top_tb: FAIL");
    end
    $finish;
  end

endmodule
